// File: hdl/fct_pkg.sv
package fct_pkg;

  // Plane registers and how many of them take part in a test
  localparam int unsigned PlaneRegs  = 6;
  localparam int unsigned PlaneCount = 6;
  localparam int unsigned NumTested  = (PlaneCount < PlaneRegs) ? PlaneCount : PlaneRegs;

  localparam int unsigned CfgIdxW = $clog2(PlaneRegs + 1);
  localparam int unsigned PlaneW  = 64;
  localparam int unsigned CoefW   = 16;
  localparam int unsigned PosW    = 16;
  localparam int unsigned ExtW    = 15;
  localparam int unsigned ProdW   = CoefW + PosW;   // Q10.22 product
  localparam int unsigned SumAbsW = CoefW + 2;      // |a|+|b|+|c|
  localparam int unsigned BiasW   = ExtW + SumAbsW; // extent * sum of magnitudes
  localparam int unsigned FracSh  = 14;             // Q8.8 -> Q.22
  localparam int unsigned DistW   = 36;

  typedef enum logic [1:0] {
    OpPoint  = 2'd0,
    OpSphere = 2'd1,
    OpCube   = 2'd2
  } op_e;

  typedef struct packed {
    logic signed [CoefW-1:0] d;
    logic signed [CoefW-1:0] c;
    logic signed [CoefW-1:0] b;
    logic signed [CoefW-1:0] a;
  } plane_t;

  // Magnitude of a signed 16-bit coefficient, exact for the most negative value
  function automatic logic [CoefW:0] coef_abs(input logic signed [CoefW-1:0] v);
    logic [CoefW:0] ext;
    ext = {v[CoefW-1], v};
    return v[CoefW-1] ? (~ext + {{CoefW{1'b0}}, 1'b1}) : ext;
  endfunction

  function automatic logic [SumAbsW-1:0] plane_reach(input plane_t p);
    return SumAbsW'(coef_abs(p.a)) + SumAbsW'(coef_abs(p.b)) + SumAbsW'(coef_abs(p.c));
  endfunction

endpackage

// File: hdl/frustum_containment_test.sv
// Channel | Direction | Handshake             | Payload
// --------+-----------+-----------------------+-----------------------------------------
// in      | input     | in_valid_i/in_ready_o | operation_i, pos_x_i, pos_y_i, pos_z_i,
//         |           |                       | extent_i
// out     | output    | out_valid_o/out_ready_i | inside_res_o
// cfg     | input     | cfg_valid_i/cfg_ready_o | cfg_index_i, cfg_data_i
//
// One word per cycle when the output side takes every word; the accept edge loads
// the input register, then the product register and the result register follow in
// that order, and out_valid_o rises with the result register.
// The plane multipliers (three per plane plus the extent reach product) set the path
// into the product register; the wide distance add and sign test set the path into
// the result register.
// Reset clears all valid flags and every plane register to zero.
// A held output word stalls all three stages together; in_ready_o drops only then.
module frustum_containment_test (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // input words
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    operation_i,
  input  logic signed [fct_pkg::PosW-1:0] pos_x_i,
  input  logic signed [fct_pkg::PosW-1:0] pos_y_i,
  input  logic signed [fct_pkg::PosW-1:0] pos_z_i,
  input  logic [fct_pkg::ExtW-1:0]      extent_i,
  // result words
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic                          inside_res_o,
  // plane register writes
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [fct_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [fct_pkg::PlaneW-1:0]    cfg_data_i
);

  // Plane registers, plus the precomputed |a|+|b|+|c| of each plane
  logic [fct_pkg::PlaneRegs-1:0][fct_pkg::PlaneW-1:0]  plane_q;
  logic [fct_pkg::PlaneRegs-1:0][fct_pkg::SumAbsW-1:0] sumabs_q;

  // Stage 1: registered input word
  logic                            v1_q;
  logic [1:0]                      op1_q;
  logic signed [fct_pkg::PosW-1:0] x1_q, y1_q, z1_q;
  logic [fct_pkg::ExtW-1:0]        e1_q;

  // Stage 2: registered products and the per-operation bias
  logic                             v2_q;
  logic signed [fct_pkg::ProdW-1:0] px2_q [fct_pkg::NumTested];
  logic signed [fct_pkg::ProdW-1:0] py2_q [fct_pkg::NumTested];
  logic signed [fct_pkg::ProdW-1:0] pz2_q [fct_pkg::NumTested];
  logic [fct_pkg::BiasW-1:0]        bias2_q [fct_pkg::NumTested];

  // Stage 3: result word
  logic out_valid_q;
  logic inside_q;

  logic advance;
  logic [fct_pkg::NumTested-1:0] reject;

  // Whole pipe moves unless the output holds a word nobody takes
  assign advance     = !out_valid_q || out_ready_i;
  assign in_ready_o  = advance;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign inside_res_o = inside_q;

  // Plane register writes; drop writes beyond the last plane
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      plane_q  <= '0;
      sumabs_q <= '0;
    end else if (cfg_valid_i && (cfg_index_i < fct_pkg::CfgIdxW'(fct_pkg::PlaneRegs))) begin
      for (int i = 0; i < fct_pkg::PlaneRegs; i++) begin
        if (cfg_index_i == fct_pkg::CfgIdxW'(i)) begin
          plane_q[i]  <= cfg_data_i;
          sumabs_q[i] <= fct_pkg::plane_reach(fct_pkg::plane_t'(cfg_data_i));
        end
      end
    end
  end

  // Valid flags of the three stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else if (advance) begin
      v1_q        <= in_valid_i;
      v2_q        <= v1_q;
      out_valid_q <= v2_q;
    end
  end

  // Stage 1 payload: capture the incoming word
  always_ff @(posedge clk_i) begin
    if (advance) begin
      op1_q <= operation_i;
      x1_q  <= pos_x_i;
      y1_q  <= pos_y_i;
      z1_q  <= pos_z_i;
      e1_q  <= extent_i;
    end
  end

  // Per-plane datapath
  for (genvar p = 0; p < fct_pkg::NumTested; p++) begin : g_plane
    fct_pkg::plane_t                  pl;
    logic [fct_pkg::BiasW-1:0]        reach;
    logic [fct_pkg::BiasW-1:0]        bias_d;
    logic signed [fct_pkg::DistW-1:0] plane_dist;

    assign pl    = fct_pkg::plane_t'(plane_q[p]);
    assign reach = fct_pkg::BiasW'(e1_q) * fct_pkg::BiasW'(sumabs_q[p]);

    // Fold the threshold into one bias: D + bias <= 0 rejects
    always_comb begin
      case (op1_q)
        fct_pkg::OpPoint:  bias_d = '0;
        fct_pkg::OpSphere: bias_d = fct_pkg::BiasW'({e1_q, {fct_pkg::FracSh{1'b0}}});
        default:           bias_d = reach; // cube, and the unused code 3
      endcase
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        px2_q[p]   <= pl.a * x1_q;
        py2_q[p]   <= pl.b * y1_q;
        pz2_q[p]   <= pl.c * z1_q;
        bias2_q[p] <= bias_d;
      end
    end

    // Signed distance plus bias for this plane in Q.22; exact at this width
    assign plane_dist = fct_pkg::DistW'(px2_q[p]) + fct_pkg::DistW'(py2_q[p])
                + fct_pkg::DistW'(pz2_q[p])
                + {{(fct_pkg::DistW - fct_pkg::CoefW - fct_pkg::FracSh){pl.d[fct_pkg::CoefW-1]}},
                   pl.d, {fct_pkg::FracSh{1'b0}}}
                + {{(fct_pkg::DistW - fct_pkg::BiasW){1'b0}}, bias2_q[p]};

    assign reject[p] = plane_dist[fct_pkg::DistW-1] || (plane_dist == '0);
  end

  // Stage 3 payload: inside unless some plane rejects
  always_ff @(posedge clk_i) begin
    if (advance) begin
      inside_q <= ~|reject;
    end
  end

  a_in_to_stage1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> v1_q)
    else $error("accepted word did not enter stage 1");

  a_stall_only_on_held_word : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> out_valid_q)
    else $error("input stalled with no word held at the output");

  a_stage2_holds : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v2_q && !advance) |=> (v2_q && $stable(bias2_q[0])))
    else $error("stage 2 word lost during stall");

  a_bad_index_ignored : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && (cfg_index_i >= fct_pkg::CfgIdxW'(fct_pkg::PlaneRegs)))
      |=> $stable(plane_q))
    else $error("write beyond the last plane changed a plane");

endmodule

// File: verif/frustum_containment_test_test.sv
`timescale 1ns / 1ps

module frustum_containment_test_test;

  // The spare operation code decodes as a cube through the default branch
  localparam logic [1:0] OpSpare = 2'd3;
  // Register indexes past the last plane; writes there must be dropped
  localparam logic [fct_pkg::CfgIdxW-1:0] IdxSpareLo = fct_pkg::CfgIdxW'(fct_pkg::PlaneRegs);
  localparam logic [fct_pkg::CfgIdxW-1:0] IdxSpareHi = '1;
  localparam int UnitCoef = 16384;  // 1.0 in Q2.14
  localparam int UnitPos  = 256;    // 1.0 in Q8.8
  // Pipeline is three deep; let it settle before touching the planes
  localparam int SettleCycles = 8;
  localparam int MaxGap = 40;

  logic                            clk_i = 1'b0;
  logic                            rst_ni = 1'b0;
  logic                            in_valid_i = 1'b0;
  logic                            in_ready_o;
  logic [1:0]                      operation_i = '0;
  logic signed [fct_pkg::PosW-1:0] pos_x_i = '0;
  logic signed [fct_pkg::PosW-1:0] pos_y_i = '0;
  logic signed [fct_pkg::PosW-1:0] pos_z_i = '0;
  logic [fct_pkg::ExtW-1:0]        extent_i = '0;
  logic                            out_valid_o;
  logic                            out_ready_i = 1'b0;
  logic                            inside_res_o;
  logic                            cfg_valid_i = 1'b0;
  logic                            cfg_ready_o;
  logic [fct_pkg::CfgIdxW-1:0]     cfg_index_i = '0;
  logic [fct_pkg::PlaneW-1:0]      cfg_data_i = '0;

  frustum_containment_test dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .operation_i  (operation_i),
    .pos_x_i      (pos_x_i),
    .pos_y_i      (pos_y_i),
    .pos_z_i      (pos_z_i),
    .extent_i     (extent_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .inside_res_o (inside_res_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always #10 clk_i = ~clk_i;

  // Shadow of the plane registers, updated on every accepted write to a plane register
  fct_pkg::plane_t planes_m [fct_pkg::PlaneRegs];
  // Inside flags still owed by the block, oldest first
  bit     inside_q [$];
  // Half-widths of the current box frustum, Q8.8, one per axis
  int     box_half [3];

  int idle_pct  = 0;
  int stall_pct = 0;
  int errors    = 0;
  int n_point   = 0;
  int n_sphere  = 0;
  int n_cube    = 0;
  int n_inside  = 0;
  int n_words   = 0;
  int n_writes  = 0;
  bit want;

  // Exact signed distance per plane in Q.22; the first plane that rejects wins
  function automatic bit object_inside(logic [1:0] op, logic signed [fct_pkg::PosW-1:0] x,
                                       logic signed [fct_pkg::PosW-1:0] y,
                                       logic signed [fct_pkg::PosW-1:0] z,
                                       logic [fct_pkg::ExtW-1:0] e);
    longint ca, cb, cc, cd, plane_dist, reach, ext;
    bit     reject;
    int     i;
    for (i = 0; i < fct_pkg::NumTested; i++) begin
      ca   = longint'(planes_m[i].a);
      cb   = longint'(planes_m[i].b);
      cc   = longint'(planes_m[i].c);
      cd   = longint'(planes_m[i].d);
      ext  = longint'(e);
      plane_dist = ca * longint'(x) + cb * longint'(y) + cc * longint'(z) + cd * 16384;
      case (op)
        fct_pkg::OpPoint:  reject = (plane_dist <= 0);
        fct_pkg::OpSphere: reject = (plane_dist <= -(ext * 16384));
        default: begin
          // Farthest corner along the normal lies extent*(|a|+|b|+|c|) ahead
          reach  = ext * ((ca < 0 ? -ca : ca) + (cb < 0 ? -cb : cb) + (cc < 0 ? -cc : cc));
          reject = (plane_dist + reach <= 0);
        end
      endcase
      if (reject) return 1'b0;
    end
    return 1'b1;
  endfunction

  function automatic logic [fct_pkg::PlaneW-1:0] pack_plane(int a, int b, int c, int d);
    fct_pkg::plane_t p;
    p.a = fct_pkg::CoefW'(a);
    p.b = fct_pkg::CoefW'(b);
    p.c = fct_pkg::CoefW'(c);
    p.d = fct_pkg::CoefW'(d);
    return p;
  endfunction

  // Pick a coordinate inside the box, right on a face, near it, or anywhere
  function automatic logic signed [fct_pkg::PosW-1:0] pick_coord(int half, int rim);
    int v;
    case ($urandom_range(0, 3))
      0: v = int'($urandom_range(0, 2 * half)) - half;
      1: v = (($urandom_range(0, 1) != 0) ? half + rim : -(half + rim))
             + int'($urandom_range(0, 2)) - 1;
      2: v = int'($urandom_range(0, 2 * half + 3000)) - half - 1500;
      default: v = int'($urandom_range(0, 65535)) - 32768;
    endcase
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return fct_pkg::PosW'(v);
  endfunction

  task automatic report_mismatch(string what, bit want_v, logic got);
    $display("%0t ns: inside_res %s: expected %0b, got %0b", $time, what, want_v, got);
    errors++;
  endtask

  // Send one object word; hold valid and payload until the block takes it
  task automatic send_object(logic [1:0] op, logic signed [fct_pkg::PosW-1:0] x,
                             logic signed [fct_pkg::PosW-1:0] y,
                             logic signed [fct_pkg::PosW-1:0] z,
                             logic [fct_pkg::ExtW-1:0] e);
    bit flag;
    int gap;
    gap = 0;
    while ($urandom_range(99) < idle_pct && gap < MaxGap) gap++;
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i  <= 1'b1;
    operation_i <= op;
    pos_x_i     <= x;
    pos_y_i     <= y;
    pos_z_i     <= z;
    extent_i    <= e;
    flag = object_inside(op, x, y, z, e);
    do @(posedge clk_i); while (!in_ready_o);
    inside_q.push_back(flag);
    if (flag) n_inside++;
    case (op)
      fct_pkg::OpPoint:  n_point++;
      fct_pkg::OpSphere: n_sphere++;
      default:           n_cube++;
    endcase
  endtask

  // Drop valid and wait until every owed word is back and the pipe is empty
  task automatic quiesce();
    in_valid_i <= 1'b0;
    while (inside_q.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Leaves cfg_valid_i high so back-to-back writes need no gap
  task automatic write_plane(logic [fct_pkg::CfgIdxW-1:0] idx,
                             logic [fct_pkg::PlaneW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    if (idx < fct_pkg::PlaneRegs) planes_m[idx] = fct_pkg::plane_t'(data);
    n_writes++;
  endtask

  task automatic load_planes(input logic [fct_pkg::PlaneW-1:0] regs [fct_pkg::PlaneRegs]);
    int i;
    quiesce();
    for (i = 0; i < fct_pkg::PlaneRegs; i++) write_plane(fct_pkg::CfgIdxW'(i), regs[i]);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic load_uniform(logic [fct_pkg::PlaneW-1:0] data);
    logic [fct_pkg::PlaneW-1:0] regs [fct_pkg::PlaneRegs];
    int i;
    for (i = 0; i < fct_pkg::PlaneRegs; i++) regs[i] = data;
    load_planes(regs);
  endtask

  // Axis-aligned box, one plane pair per axis; tilt adds small off-axis terms
  task automatic load_box(int hx, int hy, int hz, bit tilt);
    logic [fct_pkg::PlaneW-1:0] regs [fct_pkg::PlaneRegs];
    int coef [3];
    int k, s, j;
    box_half[0] = hx;
    box_half[1] = hy;
    box_half[2] = hz;
    for (k = 0; k < 3; k++) begin
      for (s = 0; s < 2; s++) begin
        for (j = 0; j < 3; j++)
          coef[j] = tilt ? int'($urandom_range(0, 2047)) - 1024 : 0;
        coef[k] = s ? -UnitCoef : UnitCoef;
        regs[2 * k + s] = pack_plane(coef[0], coef[1], coef[2], box_half[k]);
      end
    end
    load_planes(regs);
  endtask

  // Planes straight out of reset are all zero: D is zero everywhere
  task automatic test_reset_planes();
    send_object(fct_pkg::OpPoint, '0, '0, '0, '0);
    send_object(fct_pkg::OpPoint, 16'sh7fff, 16'sh8000, 16'sh7fff, '1);
    send_object(fct_pkg::OpSphere, '0, '0, '0, '0);
    send_object(fct_pkg::OpSphere, 16'sh8000, 16'sh8000, 16'sh8000, 15'd1);
    send_object(fct_pkg::OpCube, 16'sh7fff, 16'sh7fff, 16'sh7fff, '1);
    send_object(OpSpare, '0, '0, '0, 15'd5);
  endtask

  // Unit box of half-size 10.0: hit each face exactly and one step inside
  task automatic test_box_faces();
    load_box(10 * UnitPos, 10 * UnitPos, 10 * UnitPos, 1'b0);
    send_object(fct_pkg::OpPoint, '0, '0, '0, '0);
    send_object(fct_pkg::OpPoint, 16'sd2560, '0, '0, '0);
    send_object(fct_pkg::OpPoint, 16'sd2559, '0, '0, '0);
    send_object(fct_pkg::OpSphere, 16'sd3072, '0, '0, 15'd512);
    send_object(fct_pkg::OpSphere, 16'sd3072, '0, '0, 15'd513);
    send_object(fct_pkg::OpCube, '0, -16'sd3072, '0, 15'd512);
    send_object(fct_pkg::OpCube, '0, -16'sd3072, '0, 15'd513);
    send_object(OpSpare, '0, '0, 16'sd3072, 15'd512);
    send_object(OpSpare, '0, '0, 16'sd3072, 15'd513);
    // Extent must not rescue a point
    send_object(fct_pkg::OpPoint, 16'sd8000, '0, '0, '1);
    send_object(fct_pkg::OpSphere, '0, 16'sh8000, '0, '1);
  endtask

  // Coefficients at their extremes, then writes past the last plane
  task automatic test_extreme_planes();
    load_uniform({4{16'h8000}});
    send_object(fct_pkg::OpPoint, 16'sh8000, 16'sh8000, 16'sh8000, '0);
    send_object(fct_pkg::OpCube, 16'sh7fff, 16'sh7fff, 16'sh7fff, '1);
    load_uniform({4{16'h7fff}});
    send_object(fct_pkg::OpSphere, 16'sh8000, 16'sh8000, 16'sh8000, '1);
    send_object(fct_pkg::OpPoint, 16'sh7fff, 16'sh7fff, 16'sh7fff, '0);
    load_uniform('1);
    send_object(fct_pkg::OpCube, '0, '0, '0, 15'd16383);
    load_uniform('0);
    write_plane(IdxSpareLo, '1);
    write_plane(IdxSpareHi, {4{16'h4000}});
    cfg_valid_i <= 1'b0;
    send_object(fct_pkg::OpPoint, '0, '0, '0, '0);
    send_object(fct_pkg::OpSphere, '0, '0, '0, 15'd1);
  endtask

  task automatic run_box_batch(int n, bit tilt);
    logic [1:0]               op;
    logic [fct_pkg::ExtW-1:0] e;
    int                       rim, i;
    load_box($urandom_range(4, 4000), $urandom_range(4, 4000), $urandom_range(4, 4000), tilt);
    for (i = 0; i < n; i++) begin
      op  = 2'($urandom_range(0, 3));
      e   = ($urandom_range(0, 3) == 0) ? fct_pkg::ExtW'($urandom_range(0, 32767))
                                        : fct_pkg::ExtW'($urandom_range(0, 800));
      rim = (op == fct_pkg::OpPoint) ? 0 : int'(e);
      send_object(op, pick_coord(box_half[0], rim), pick_coord(box_half[1], rim),
                  pick_coord(box_half[2], rim), e);
    end
  endtask

  // Arbitrary plane bits and arbitrary objects; mostly rejections
  task automatic run_noise_batch(int n);
    logic [fct_pkg::PlaneW-1:0] regs [fct_pkg::PlaneRegs];
    int i;
    for (i = 0; i < fct_pkg::PlaneRegs; i++) regs[i] = {$urandom, $urandom};
    load_planes(regs);
    for (i = 0; i < n; i++)
      send_object(2'($urandom_range(0, 3)), fct_pkg::PosW'($urandom),
                  fct_pkg::PosW'($urandom), fct_pkg::PosW'($urandom),
                  fct_pkg::ExtW'($urandom));
  endtask

  // Four idling phases: none, sender gaps, receiver stalls, then both
  task automatic test_random();
    int phase;
    for (phase = 0; phase < 4; phase++) begin
      idle_pct  = (phase == 1) ? 46 : (phase == 3) ? 8 : 0;
      stall_pct = (phase == 2) ? 46 : (phase == 3) ? 8 : 0;
      run_box_batch(180, 1'b0);
      run_box_batch(150, 1'b1);
      run_noise_batch(90);
    end
  endtask

  // Drive random backpressure and check every word the block hands over
  always @(posedge clk_i) begin
    out_ready_i <= ($urandom_range(99) >= stall_pct);
    if (rst_ni && out_valid_o && out_ready_i) begin
      n_words++;
      if (inside_q.size() == 0) begin
        report_mismatch("word with nothing owed", 1'b0, inside_res_o);
      end else begin
        want = inside_q.pop_front();
        if (inside_res_o !== want) report_mismatch("mismatch", want, inside_res_o);
      end
    end
  end

  initial begin
    int i;
    for (i = 0; i < fct_pkg::PlaneRegs; i++) planes_m[i] = '0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_reset_planes();
    test_box_faces();
    test_extreme_planes();
    test_random();
    quiesce();
    $display("covered %0d objects (%0d point, %0d sphere, %0d cube incl. spare op), %0d inside",
             n_point + n_sphere + n_cube, n_point, n_sphere, n_cube, n_inside);
    $display("checked %0d result words across %0d plane writes and four idling phases",
             n_words, n_writes);
    if (errors == 0) begin
      $display("frustum_containment_test_test passed");
    end else begin
      $display("frustum_containment_test_test failed");
    end
    $finish;
  end

  // Hang guard
  initial begin
    #5_000_000;
    $display("frustum_containment_test_test failed");
    $finish;
  end

endmodule

// File: frustum_containment_test.f
hdl/fct_pkg.sv
hdl/frustum_containment_test.sv
verif/frustum_containment_test_test.sv
